// File: rtl/core/pes_pkg.sv
package pes_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CFG_W = 7;
	localparam int VAL_W = 32;

	// one chain entry; the sort key is {unsorted, value or arrival index}
	typedef struct packed {
		logic               valid;
		logic               unsorted;
		logic [IDX_W-1:0]   idx;
		logic [VAL_W-1:0]   value;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} ctrl_t;

	// prefix entries order by signed value and come before the tail,
	// tail entries order by arrival index
	function automatic logic pes_less(input entry_t a, input entry_t b);
		logic r;
		if (a.unsorted != b.unsorted) begin
			r = b.unsorted;
		end else if (!a.unsorted) begin
			r = $signed(a.value) < $signed(b.value);
		end else begin
			r = a.idx < b.idx;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/prefix_exchange_sorter.sv
// timing: the item marked last starts the output in the cycle after it is
//   taken, then one stored value leaves per cycle while m_tready is high
// sequencing: the insertion chain takes one value a cycle while loading, then
//   drains; no new value is taken until the previous sequence has drained
// reset: arst_n clears the chain valid bits, fill count, drop flag, state
//   and sort_count; stored payloads are not reset
module prefix_exchange_sorter
	import pes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] value
	input  logic             s_tlast,   // is_last
	// output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,   // [31:0] out_value
	output logic             m_tlast,   // out_last
	output logic [0:0]       m_tuser,   // [0] overflowed
	// configuration
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata  // sort_count
);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic               state_q;
	logic [CNT_W-1:0]   fill_q;
	logic               drop_q;
	logic [CFG_W-1:0]   sort_count_q;

	logic               in_xfer;
	logic               out_xfer;
	logic               room;
	ctrl_t              ctrl;
	entry_t             new_ent;
	entry_t             ent [DEPTH];
	logic               gt  [DEPTH];

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign room     = fill_q < CNT_W'(DEPTH);

	// values at positions below sort_count are keyed by value, the rest
	// by arrival index, so one insertion chain yields both orders
	assign new_ent.valid    = 1'b1;
	assign new_ent.unsorted = CFG_W'(fill_q) >= sort_count_q;
	assign new_ent.idx      = fill_q[IDX_W-1:0];
	assign new_ent.value    = s_tdata;

	assign ctrl.ins   = in_xfer && room;
	assign ctrl.shift = out_xfer;

	// chain of cells: broadcast insert while loading, shift toward cell 0
	// while emitting
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t l_ent;
		logic   l_gt;
		entry_t r_ent;
		if (i == 0) begin : g_first
			assign l_ent = '0;
			assign l_gt  = 1'b0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_gt  = gt[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign r_ent = '0;
		end else begin : g_inner
			assign r_ent = ent[i+1];
		end
		pes_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_ent   (new_ent),
			.left_ent  (l_ent),
			.left_gt   (l_gt),
			.right_ent (r_ent),
			.ent       (ent[i]),
			.gt        (gt[i])
		);
	end

	// head of the chain is the output register
	assign s_tready   = state_q == ST_LOAD;
	assign m_tvalid   = state_q == ST_EMIT;
	assign m_tdata    = ent[0].value;
	assign m_tlast    = !ent[1].valid;
	assign m_tuser[0] = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_count_q <= '0;
		end else if (cfg_we) begin
			sort_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (room) begin
							fill_q <= fill_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					// last transfer of the sequence: start a fresh one
					if (out_xfer && m_tlast) begin
						state_q <= ST_LOAD;
						fill_q  <= '0;
						drop_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// something to show whenever the output is valid
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ent[0].valid)
		else $error("output valid with empty chain head");

	// emission keeps going until the marked final value
	a_emit_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !m_tlast) |=> m_tvalid)
		else $error("emission stopped before final value");

	// a transfer into a full chain is flagged
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !room) |=> drop_q)
		else $error("dropped value not flagged");

	// loading and draining never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during emission");

endmodule

// File: rtl/core/pes_cell.sv
module pes_cell
	import pes_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  ctrl_t  ctrl,
	input  entry_t new_ent,
	input  entry_t left_ent,
	input  logic   left_gt,
	input  entry_t right_ent,
	output entry_t ent,
	output logic   gt
);

	logic               valid_q;
	logic               unsorted_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VAL_W-1:0]   value_q;
	entry_t             nxt;
	logic               upd;

	assign ent = '{valid: valid_q, unsorted: unsorted_q, idx: idx_q, value: value_q};

	// new entry belongs at or before this cell
	assign gt = !valid_q || pes_less(new_ent, ent);

	always_comb begin
		nxt = ent;
		upd = 1'b0;
		if (ctrl.shift) begin
			nxt = right_ent;
			upd = 1'b1;
		end else if (ctrl.ins && gt) begin
			nxt = left_gt ? left_ent : new_ent;
			upd = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			unsorted_q <= nxt.unsorted;
			idx_q      <= nxt.idx;
			value_q    <= nxt.value;
		end
	end

endmodule
